@@ rtl/core/gpr_pkg.sv @@
// Package for the GPIO port register block: register codes, pin masks and field spread helpers.
`timescale 1ns / 1ps
`default_nettype none

package gpr_pkg;

	// Number of pins that exist in this port.
	localparam int PIN_COUNT = 16;

	// Mask of the pins that exist, one bit per pin.
	localparam logic [15:0] PIN_MASK = 16'((33'd1 << PIN_COUNT) - 33'd1);

	// Access kinds.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Register indexes.
	localparam logic [3:0] REG_MODE     = 4'd0;
	localparam logic [3:0] REG_OTYPE    = 4'd1;
	localparam logic [3:0] REG_SPEED    = 4'd2;
	localparam logic [3:0] REG_PULL     = 4'd3;
	localparam logic [3:0] REG_IDR      = 4'd4;
	localparam logic [3:0] REG_ODR      = 4'd5;
	localparam logic [3:0] REG_BSRR     = 4'd6;
	localparam logic [3:0] REG_LOCK     = 4'd7;
	localparam logic [3:0] REG_AFR_LOW  = 4'd8;
	localparam logic [3:0] REG_AFR_HIGH = 4'd9;

	// Lock key sequence steps.
	localparam logic [1:0] LOCK_IDLE  = 2'd0;
	localparam logic [1:0] LOCK_STEP1 = 2'd1;
	localparam logic [1:0] LOCK_STEP2 = 2'd2;

	// Bit position of the lock key in a lock write.
	localparam int LOCK_KEY_BIT = 16;

	// Widen a pin mask to two bits per pin.
	function automatic logic [31:0] spread2(input logic [15:0] pins);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			r[2*k +: 2] = {2{pins[k]}};
		end
		return r;
	endfunction

	// Widen eight pins of a mask to four bits per pin.
	function automatic logic [31:0] spread4(input logic [7:0] pins);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			r[4*k +: 4] = {4{pins[k]}};
		end
		return r;
	endfunction

	// Write the unfrozen valid bits of a register, keep the rest, clear invalid bits.
	function automatic logic [31:0] merge(input logic [31:0] old_val, input logic [31:0] data,
			input logic [31:0] frozen, input logic [31:0] valid);
		logic [31:0] wmask;
		wmask = valid & ~frozen;
		return ((old_val & ~wmask) | (data & wmask)) & valid;
	endfunction

	// Valid field masks derived from the pin count.
	localparam logic [31:0] MASK2     = spread2(PIN_MASK);
	localparam logic [31:0] MASK4_LOW = spread4(PIN_MASK[7:0]);
	localparam logic [31:0] MASK4_HI  = spread4(PIN_MASK[15:8]);

endpackage

`default_nettype wire

@@ rtl/core/gpio_port_register_block.sv @@
// Top level of the 16-pin GPIO port register block with set/reset and configuration lock.
//
//   Channel   Direction  tdata fields (lowest bit first)
//   s_axis    in         op[0], reg_index[4:1], write_data[36:5], pad_levels[52:37], zero pad
//   m_axis    out        read_data[31:0], pin_drive[47:32], access_error[48], zero pad
//
// Each request is handled at its accepting edge: the register file is read and updated
// there and the response is held in one output register. A new request is accepted every
// cycle while the response register is empty or being taken in the same cycle.
// Reset clears all port registers, the lock and the lock key sequence; no sweep is needed.
// A stall on the output side holds the response and stops acceptance until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module gpio_port_register_block (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // op, reg_index, write_data, pad_levels, zero pad
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata   // read_data, pin_drive, access_error, zero pad
);

	// Request fields.
	logic        op;
	logic [3:0]  reg_index;
	logic [31:0] write_data;
	logic [15:0] pad_levels;

	assign op         = s_axis_tdata[0];
	assign reg_index  = s_axis_tdata[4:1];
	assign write_data = s_axis_tdata[36:5];
	assign pad_levels = s_axis_tdata[52:37];

	// Port registers.
	logic [31:0] mode_q, speed_q, pull_q, afr_low_q, afr_high_q;
	logic [15:0] otype_q, odr_q, locked_pins_q, lock_mask_q;
	logic        lock_active_q;
	logic [1:0]  lock_step_q;

	// Next values.
	logic [31:0] mode_d, speed_d, pull_d, afr_low_d, afr_high_d;
	logic [15:0] otype_d, odr_d, locked_pins_d, lock_mask_d;
	logic        lock_active_d;
	logic [1:0]  lock_step_d;
	logic [31:0] read_data;
	logic        access_error;

	// Response register.
	logic        valid_s1;
	logic [31:0] read_data_s1;
	logic [15:0] pin_drive_s1;
	logic        access_error_s1;

	logic        accept;
	logic [31:0] locked2;
	logic        lock_key;
	logic [15:0] lock_wmask;

	assign s_axis_tready = !valid_s1 || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign locked2    = gpr_pkg::spread2(locked_pins_q);
	assign lock_key   = write_data[gpr_pkg::LOCK_KEY_BIT];
	assign lock_wmask = write_data[15:0] & gpr_pkg::PIN_MASK;

	// Register read and update for one request.
	always_comb begin
		mode_d        = mode_q;
		otype_d       = otype_q;
		speed_d       = speed_q;
		pull_d        = pull_q;
		odr_d         = odr_q;
		afr_low_d     = afr_low_q;
		afr_high_d    = afr_high_q;
		locked_pins_d = locked_pins_q;
		lock_active_d = lock_active_q;
		lock_step_d   = lock_step_q;
		lock_mask_d   = lock_mask_q;
		read_data     = '0;
		access_error  = 1'b0;
		if (op == gpr_pkg::OP_READ) begin
			unique case (reg_index)
				gpr_pkg::REG_MODE:     read_data = mode_q;
				gpr_pkg::REG_OTYPE:    read_data = {16'd0, otype_q};
				gpr_pkg::REG_SPEED:    read_data = speed_q;
				gpr_pkg::REG_PULL:     read_data = pull_q;
				gpr_pkg::REG_IDR:      read_data = {16'd0, pad_levels & gpr_pkg::PIN_MASK};
				gpr_pkg::REG_ODR:      read_data = {16'd0, odr_q};
				gpr_pkg::REG_BSRR:     read_data = '0;
				gpr_pkg::REG_LOCK:     read_data = {15'd0, lock_active_q, locked_pins_q};
				gpr_pkg::REG_AFR_LOW:  read_data = afr_low_q;
				gpr_pkg::REG_AFR_HIGH: read_data = afr_high_q;
				default:               access_error = 1'b1;
			endcase
		end else begin
			unique case (reg_index)
				gpr_pkg::REG_MODE:
					mode_d = gpr_pkg::merge(mode_q, write_data, locked2, gpr_pkg::MASK2);
				gpr_pkg::REG_OTYPE:
					otype_d = 16'(gpr_pkg::merge({16'd0, otype_q}, write_data,
						{16'd0, locked_pins_q}, {16'd0, gpr_pkg::PIN_MASK}));
				gpr_pkg::REG_SPEED:
					speed_d = gpr_pkg::merge(speed_q, write_data, locked2, gpr_pkg::MASK2);
				gpr_pkg::REG_PULL:
					pull_d = gpr_pkg::merge(pull_q, write_data, locked2, gpr_pkg::MASK2);
				gpr_pkg::REG_IDR:
					access_error = 1'b1;
				gpr_pkg::REG_ODR:
					odr_d = write_data[15:0] & gpr_pkg::PIN_MASK;
				gpr_pkg::REG_BSRR:
					// Set wins over clear for the same pin.
					odr_d = ((odr_q & ~write_data[31:16]) | write_data[15:0])
						& gpr_pkg::PIN_MASK;
				gpr_pkg::REG_LOCK: begin
					// Three-write key sequence; ignored once the lock is active.
					if (!lock_active_q) begin
						if (lock_step_q == gpr_pkg::LOCK_STEP1 && !lock_key
								&& lock_wmask == lock_mask_q) begin
							lock_step_d = gpr_pkg::LOCK_STEP2;
						end else if (lock_step_q == gpr_pkg::LOCK_STEP2 && lock_key
								&& lock_wmask == lock_mask_q) begin
							locked_pins_d = lock_wmask;
							lock_active_d = 1'b1;
							lock_step_d   = gpr_pkg::LOCK_IDLE;
						end else if (lock_key) begin
							lock_mask_d = lock_wmask;
							lock_step_d = gpr_pkg::LOCK_STEP1;
						end else begin
							lock_step_d = gpr_pkg::LOCK_IDLE;
						end
					end
				end
				gpr_pkg::REG_AFR_LOW:
					afr_low_d = gpr_pkg::merge(afr_low_q, write_data,
						gpr_pkg::spread4(locked_pins_q[7:0]), gpr_pkg::MASK4_LOW);
				gpr_pkg::REG_AFR_HIGH:
					afr_high_d = gpr_pkg::merge(afr_high_q, write_data,
						gpr_pkg::spread4(locked_pins_q[15:8]), gpr_pkg::MASK4_HI);
				default:
					access_error = 1'b1;
			endcase
		end
	end

	// Port register state, updated on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= '0;
			otype_q       <= '0;
			speed_q       <= '0;
			pull_q        <= '0;
			odr_q         <= '0;
			afr_low_q     <= '0;
			afr_high_q    <= '0;
			locked_pins_q <= '0;
			lock_active_q <= 1'b0;
			lock_step_q   <= gpr_pkg::LOCK_IDLE;
			lock_mask_q   <= '0;
		end else if (accept) begin
			mode_q        <= mode_d;
			otype_q       <= otype_d;
			speed_q       <= speed_d;
			pull_q        <= pull_d;
			odr_q         <= odr_d;
			afr_low_q     <= afr_low_d;
			afr_high_q    <= afr_high_d;
			locked_pins_q <= locked_pins_d;
			lock_active_q <= lock_active_d;
			lock_step_q   <= lock_step_d;
			lock_mask_q   <= lock_mask_d;
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_s1    <= read_data;
			pin_drive_s1    <= odr_d;
			access_error_s1 <= access_error;
		end
	end

	assign m_axis_tvalid = valid_s1;
	assign m_axis_tdata  = {7'd0, access_error_s1, pin_drive_s1, read_data_s1};

endmodule

`default_nettype wire

@@ rtl/core/gpr_checker.sv @@
// Port-level checks for the GPIO port register block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module gpr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [55:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [55:0] m_axis_tdata
);

	logic s_accept;

	assign s_accept = s_axis_tvalid && s_axis_tready;

	// A held response stays unchanged until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("response changed while stalled");

	// The block takes requests whenever its response register is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("request refused with an empty response register");

	// A write request always returns zero read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_axis_tdata[0] == gpr_pkg::OP_WRITE
		|=> m_axis_tvalid && m_axis_tdata[31:0] == 32'd0)
		else $error("write request returned read data");

	// An output data write shows up on the pin drive of its response.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_axis_tdata[0] == gpr_pkg::OP_WRITE
			&& s_axis_tdata[4:1] == gpr_pkg::REG_ODR
		|=> m_axis_tdata[47:32] == ($past(s_axis_tdata[20:5]) & gpr_pkg::PIN_MASK))
		else $error("output data write not reflected on pin drive");

	// An index beyond the register list flags an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_axis_tdata[4:1] > gpr_pkg::REG_AFR_HIGH
		|=> m_axis_tdata[48])
		else $error("unknown register index not flagged");

endmodule

bind gpio_port_register_block gpr_checker u_gpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
